@@ src/mali_pkg.sv @@
// shared types, constants and codes of the multi-axis linear interpolator
`timescale 1ns / 1ps

package mali_pkg;

    localparam int NUM_AXES      = 5;
    localparam int PULSE_BITS    = 12;
    localparam int FRAC_BITS_DEF = 16;
    localparam int DUR_W         = 16;
    localparam int PER_W         = 10;
    localparam int CFG_W         = 16;
    localparam int CFG_ADDR_W    = 2;

    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 64;
    localparam int OUT_TUSER_W = 2;

    // opcodes
    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_PULSE_MIN   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PULSE_MAX   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_DEF_DUR     = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_STEP_PERIOD = 2'd3;

    // register reset values
    localparam logic [PULSE_BITS-1:0] RST_PULSE_MIN   = 12'd500;
    localparam logic [PULSE_BITS-1:0] RST_PULSE_MAX   = 12'd2500;
    localparam logic [DUR_W-1:0]      RST_DEF_DUR     = 16'd1000;
    localparam logic [PER_W-1:0]      RST_STEP_PERIOD = 10'd20;

    typedef logic [PULSE_BITS-1:0] t_pulse;
    typedef logic [NUM_AXES-1:0][PULSE_BITS-1:0] t_pulse_vec;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SDIV,
        ST_AINIT,
        ST_ADIV,
        ST_COMMIT,
        ST_TICK,
        ST_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic snap;
        logic sdiv_init;
        logic sdiv_step;
        logic adiv_init;
        logic adiv_step;
        logic commit;
        logic tick;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic any_move;
        logic div_last;
    } t_sts;

endpackage

@@ src/multi_axis_linear_interpolator.sv @@
// top level of the multi-axis linear interpolator
`timescale 1ns / 1ps

// Five servo axes move linearly from their present pulse widths to new goals.
// Input stream: tuser carries the opcode (start or tick), tdata the five goals
// and the move time. A start clamps the goals to [pulse_min, pulse_max]; if
// nothing has to move the goals land at once with done set, otherwise the
// step count (duration / step_period) and a signed 16-bit-fraction increment
// per axis are worked out, and each later tick advances the axes by one step.
// Output stream: one word per input word, tdata the five pulses, tuser busy
// and done.
// A tick passes through TICK and EMIT, a start with no motion through CHECK
// and EMIT; EMIT loads the output register. A start with motion runs the
// step divider (DUR_W = 16 quotient bits, one per step) and then the five
// increment dividers in parallel (PULSE_BITS + FRAC_BITS = 28 quotient bits).
// One word is in work at a time; the next is taken once this one's result has
// moved into the output register, which holds it while the receiver stalls.
// Configuration writes (pulse_min, pulse_max, default_duration, step_period)
// take effect on the next start. Synchronous reset restores the register
// defaults, zeroes all pulses and clears the output valid flag.

module multi_axis_linear_interpolator #(
    parameter int FRAC_BITS = mali_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // goal_1..goal_5 (12 bits each), move_time (16), zero fill
    input  logic [mali_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // opcode
    input  logic                                i_s_axis_tuser,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // pulse_1..pulse_5 (12 bits each), zero fill
    output logic [mali_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // busy_res, done_res
    output logic [mali_pkg::OUT_TUSER_W-1:0]    o_m_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    input  logic                                i_cfg_we,
    input  logic [mali_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [mali_pkg::CFG_W-1:0]          i_cfg_wdata
);

    localparam int PB      = mali_pkg::PULSE_BITS;
    localparam int GOALS_W = mali_pkg::NUM_AXES * PB;

    // configuration registers
    logic [PB-1:0]                r_pulse_min;
    logic [PB-1:0]                r_pulse_max;
    logic [mali_pkg::DUR_W-1:0]   r_def_dur;
    logic [mali_pkg::PER_W-1:0]   r_step_period;

    // output register
    logic                              r_out_valid;
    logic [mali_pkg::OUT_TDATA_W-1:0]  r_out_data;
    logic [mali_pkg::OUT_TUSER_W-1:0]  r_out_user;

    mali_pkg::t_cmd       w_cmd;
    mali_pkg::t_sts       w_sts;
    mali_pkg::t_pulse_vec w_goal;
    mali_pkg::t_pulse_vec w_pulse;
    logic                 w_busy;
    logic                 w_done;
    logic                 w_out_free;
    logic                 w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_min   <= mali_pkg::RST_PULSE_MIN;
            r_pulse_max   <= mali_pkg::RST_PULSE_MAX;
            r_def_dur     <= mali_pkg::RST_DEF_DUR;
            r_step_period <= mali_pkg::RST_STEP_PERIOD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                mali_pkg::REG_PULSE_MIN:   r_pulse_min   <= i_cfg_wdata[PB-1:0];
                mali_pkg::REG_PULSE_MAX:   r_pulse_max   <= i_cfg_wdata[PB-1:0];
                mali_pkg::REG_DEF_DUR:     r_def_dur     <= i_cfg_wdata[mali_pkg::DUR_W-1:0];
                mali_pkg::REG_STEP_PERIOD: r_step_period <= i_cfg_wdata[mali_pkg::PER_W-1:0];
                default: ;
            endcase
        end
    end

    // goals sit packed at the bottom of tdata, move time right above
    assign w_goal = i_s_axis_tdata[GOALS_W-1:0];

    // result may move in when the register is empty or being drained
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    mali_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_op    (i_s_axis_tuser),
        .i_out_free (w_out_free),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    mali_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .i_goal             (w_goal),
        .i_move_time        (i_s_axis_tdata[GOALS_W +: mali_pkg::DUR_W]),
        .i_pulse_min        (r_pulse_min),
        .i_pulse_max        (r_pulse_max),
        .i_default_duration (r_def_dur),
        .i_step_period      (r_step_period),
        .o_pulse            (w_pulse),
        .o_busy             (w_busy),
        .o_done             (w_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_cmd.emit) begin
            r_out_data <= mali_pkg::OUT_TDATA_W'(w_pulse);
            r_out_user <= {w_done, w_busy};
        end
    end

    assign o_s_axis_tready = w_in_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    // a result never overwrites one the receiver has not taken
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> (!r_out_valid || i_m_axis_tready))
        else $error("result loaded over a pending word");

    // one word in work at a time
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input taken while a word is in work");

    // a finishing word never also reports a move in progress
    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_user[0] && r_out_user[1]))
        else $error("busy and done set together");

endmodule

@@ src/mali_controller.sv @@
// sequencing state machine of the interpolator
`timescale 1ns / 1ps

module mali_controller (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_op,
    input  logic           i_out_free,
    input  mali_pkg::t_sts i_sts,
    output logic           o_in_ready,
    output mali_pkg::t_cmd o_cmd
);

    mali_pkg::t_state r_state;
    mali_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mali_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            mali_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = (i_in_op == mali_pkg::OP_TICK) ? mali_pkg::ST_TICK
                                                             : mali_pkg::ST_CHECK;
                end
            end
            mali_pkg::ST_CHECK: begin
                if (i_sts.any_move) begin
                    o_cmd.sdiv_init = 1'b1;
                    n_state = mali_pkg::ST_SDIV;
                end else begin
                    o_cmd.snap = 1'b1;
                    n_state = mali_pkg::ST_EMIT;
                end
            end
            mali_pkg::ST_SDIV: begin
                o_cmd.sdiv_step = 1'b1;
                if (i_sts.div_last) n_state = mali_pkg::ST_AINIT;
            end
            mali_pkg::ST_AINIT: begin
                o_cmd.adiv_init = 1'b1;
                n_state = mali_pkg::ST_ADIV;
            end
            mali_pkg::ST_ADIV: begin
                o_cmd.adiv_step = 1'b1;
                if (i_sts.div_last) n_state = mali_pkg::ST_COMMIT;
            end
            mali_pkg::ST_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state = mali_pkg::ST_EMIT;
            end
            mali_pkg::ST_TICK: begin
                o_cmd.tick = 1'b1;
                n_state = mali_pkg::ST_EMIT;
            end
            mali_pkg::ST_EMIT: begin
                if (i_out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = mali_pkg::ST_IDLE;
                end
            end
            default: n_state = mali_pkg::ST_IDLE;
        endcase
    end

endmodule

@@ src/mali_datapath.sv @@
// axis state, clamping, step and increment dividers, tick accumulation
`timescale 1ns / 1ps

module mali_datapath #(
    parameter int FRAC_BITS = mali_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mali_pkg::t_cmd                  i_cmd,
    output mali_pkg::t_sts                  o_sts,
    input  mali_pkg::t_pulse_vec            i_goal,
    input  logic [mali_pkg::DUR_W-1:0]      i_move_time,
    input  logic [mali_pkg::PULSE_BITS-1:0] i_pulse_min,
    input  logic [mali_pkg::PULSE_BITS-1:0] i_pulse_max,
    input  logic [mali_pkg::DUR_W-1:0]      i_default_duration,
    input  logic [mali_pkg::PER_W-1:0]      i_step_period,
    output mali_pkg::t_pulse_vec            o_pulse,
    output logic                            o_busy,
    output logic                            o_done
);

    localparam int NA    = mali_pkg::NUM_AXES;
    localparam int PB    = mali_pkg::PULSE_BITS;
    localparam int DW    = mali_pkg::DUR_W;
    localparam int PW    = mali_pkg::PER_W;
    localparam int ACC_W = PB + FRAC_BITS;
    localparam int INC_W = ACC_W + 1;
    localparam int CNT_W = $clog2(ACC_W);

    // move state
    mali_pkg::t_pulse           r_cur       [NA];
    mali_pkg::t_pulse           r_goal_store[NA];
    logic [ACC_W-1:0]           r_acc       [NA];
    logic signed [INC_W-1:0]    r_inc       [NA];
    logic [DW-1:0]              r_total;
    logic [DW-1:0]              r_count;
    logic                       r_moving;
    logic                       r_done;

    // start scratch
    mali_pkg::t_pulse           r_goal_new  [NA];
    logic [DW-1:0]              r_dur;
    logic [DW-1:0]              r_sq;
    logic [PW-1:0]              r_srem;
    logic [DW-1:0]              r_steps;
    logic [CNT_W-1:0]           r_cnt;
    logic [ACC_W-1:0]           r_lq        [NA];
    logic [DW-1:0]              r_lrem      [NA];
    logic                       r_neg       [NA];

    mali_pkg::t_pulse           n_goal      [NA];
    logic [PW-1:0]              n_period;
    logic [PW:0]                n_strial;
    logic                       n_sge;
    logic [DW-1:0]              n_steps;
    logic [DW:0]                n_ltrial    [NA];
    logic                       n_lge       [NA];
    logic                       n_neg       [NA];
    mali_pkg::t_pulse           n_mag       [NA];
    logic signed [INC_W-1:0]    n_inc       [NA];
    logic [DW-1:0]              n_count;
    logic                       n_finish;
    logic signed [INC_W:0]      n_sum       [NA];
    logic [ACC_W-1:0]           n_acc       [NA];
    logic                       n_any;

    always_comb begin
        n_any = 1'b0;
        for (int a = 0; a < NA; a++) begin
            // raise to min first, then lower to max, so max wins
            n_goal[a] = i_goal[a];
            if (n_goal[a] < i_pulse_min) n_goal[a] = i_pulse_min;
            if (n_goal[a] > i_pulse_max) n_goal[a] = i_pulse_max;

            if (r_goal_new[a] != r_cur[a]) n_any = 1'b1;
            n_neg[a] = r_goal_new[a] < r_cur[a];
            n_mag[a] = n_neg[a] ? (r_cur[a] - r_goal_new[a]) : (r_goal_new[a] - r_cur[a]);

            n_ltrial[a] = {r_lrem[a], r_lq[a][ACC_W-1]};
            n_lge[a]    = n_ltrial[a] >= {1'b0, r_steps};
            n_inc[a]    = r_neg[a] ? -$signed({1'b0, r_lq[a]}) : $signed({1'b0, r_lq[a]});

            n_sum[a] = $signed({2'b00, r_acc[a]}) + $signed({r_inc[a][INC_W-1], r_inc[a]});
            n_acc[a] = n_sum[a][INC_W] ? '0 : n_sum[a][ACC_W-1:0];
        end
        n_period = (i_step_period == '0) ? PW'(1) : i_step_period;
        n_strial = {r_srem, r_sq[DW-1]};
        n_sge    = n_strial >= {1'b0, n_period};
        n_steps  = (r_sq == '0) ? DW'(1) : r_sq;
        n_count  = r_count + DW'(1);
        n_finish = n_count >= r_total;
    end

    assign o_sts.any_move = n_any;
    assign o_sts.div_last = (r_cnt == '0);

    // dividers and start scratch, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int a = 0; a < NA; a++) r_goal_new[a] <= n_goal[a];
            r_dur <= (i_move_time == '0) ? i_default_duration : i_move_time;
        end
        if (i_cmd.sdiv_init) begin
            r_sq   <= r_dur;
            r_srem <= '0;
            r_cnt  <= CNT_W'(DW - 1);
        end
        if (i_cmd.sdiv_step) begin
            r_sq   <= {r_sq[DW-2:0], n_sge};
            r_srem <= n_sge ? PW'(n_strial - {1'b0, n_period}) : n_strial[PW-1:0];
            r_cnt  <= r_cnt - CNT_W'(1);
        end
        if (i_cmd.adiv_init) begin
            r_steps <= n_steps;
            r_cnt   <= CNT_W'(ACC_W - 1);
            for (int a = 0; a < NA; a++) begin
                r_neg[a]  <= n_neg[a];
                r_lq[a]   <= {n_mag[a], {FRAC_BITS{1'b0}}};
                r_lrem[a] <= '0;
            end
        end
        if (i_cmd.adiv_step) begin
            r_cnt <= r_cnt - CNT_W'(1);
            for (int a = 0; a < NA; a++) begin
                r_lq[a]   <= {r_lq[a][ACC_W-2:0], n_lge[a]};
                r_lrem[a] <= n_lge[a] ? DW'(n_ltrial[a] - {1'b0, r_steps})
                                      : n_ltrial[a][DW-1:0];
            end
        end
    end

    // move state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < NA; a++) begin
                r_cur[a]        <= '0;
                r_goal_store[a] <= '0;
                r_acc[a]        <= '0;
                r_inc[a]        <= '0;
            end
            r_total  <= '0;
            r_count  <= '0;
            r_moving <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            if (i_cmd.snap) begin
                for (int a = 0; a < NA; a++) r_cur[a] <= r_goal_new[a];
                r_moving <= 1'b0;
                r_done   <= 1'b1;
            end
            if (i_cmd.commit) begin
                for (int a = 0; a < NA; a++) begin
                    r_goal_store[a] <= r_goal_new[a];
                    r_inc[a]        <= n_inc[a];
                    r_acc[a]        <= {r_cur[a], {FRAC_BITS{1'b0}}};
                end
                r_total  <= r_steps;
                r_count  <= '0;
                r_moving <= 1'b1;
                r_done   <= 1'b0;
            end
            if (i_cmd.tick) begin
                r_done <= 1'b0;
                if (r_moving) begin
                    r_count <= n_count;
                    if (n_finish) begin
                        for (int a = 0; a < NA; a++) r_cur[a] <= r_goal_store[a];
                        r_moving <= 1'b0;
                        r_done   <= 1'b1;
                    end else begin
                        for (int a = 0; a < NA; a++) begin
                            r_acc[a] <= n_acc[a];
                            r_cur[a] <= n_acc[a][ACC_W-1:FRAC_BITS];
                        end
                    end
                end
            end
        end
    end

    always_comb begin
        for (int a = 0; a < NA; a++) o_pulse[a] = r_cur[a];
    end
    assign o_busy = r_moving;
    assign o_done = r_done;

endmodule
